// ----- hw/rtl/mvt_pkg.sv -----
package mvt_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_POINT  = 2'd1;
   localparam logic [1:0] KIND_VECTOR = 2'd2;

   localparam int DATA_W  = 32;
   localparam int INDEX_W = 4;
   localparam int ELEMS   = 16;
   localparam int PROD_W  = 2 * DATA_W;
   // four exact products summed plus rounding offset never exceed 66 signed bits
   localparam int SUM_W   = PROD_W + 2;

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   // 16 partial products, index 4*j+i = component j times matrix element 4*j+i
   typedef struct packed {
      prod_type [ELEMS-1:0] p;
   } prod_set_type;

   // four rounded component sums, before the shift and clip
   typedef struct packed {
      sum_type [3:0] s;
   } sum_set_type;

   typedef struct packed {
      data_type out_x;
      data_type out_y;
      data_type out_z;
      data_type out_w;
      logic     saturated;
   } rsp_data_type;

endpackage

// ----- hw/rtl/mvt_req_if.sv -----
interface mvt_req_if
   import mvt_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [1:0]            kind;
   logic [INDEX_W-1:0]    elem_index;
   logic signed [DATA_W-1:0] elem_value;
   logic signed [DATA_W-1:0] in_x;
   logic signed [DATA_W-1:0] in_y;
   logic signed [DATA_W-1:0] in_z;
   logic signed [DATA_W-1:0] in_w;

   modport source (
      output valid, kind, elem_index, elem_value, in_x, in_y, in_z, in_w,
      input  ready
   );
   modport sink (
      input  valid, kind, elem_index, elem_value, in_x, in_y, in_z, in_w,
      output ready
   );
endinterface

// ----- hw/rtl/mvt_rsp_if.sv -----
interface mvt_rsp_if
   import mvt_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_x;
   logic signed [DATA_W-1:0] out_y;
   logic signed [DATA_W-1:0] out_z;
   logic signed [DATA_W-1:0] out_w;
   logic                     saturated;

   modport source (
      output valid, out_x, out_y, out_z, out_w, saturated,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, out_w, saturated,
      output ready
   );
endinterface

// ----- hw/rtl/mvt_mul.sv -----
// Matrix store and the multiply stage: 16 products of a beat, one register stage.
module mvt_mul
   import mvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [1:0]         kind,
   input  logic [INDEX_W-1:0] elem_index,
   input  data_type           elem_value,
   input  data_type           in_x,
   input  data_type           in_y,
   input  data_type           in_z,
   input  data_type           in_w,
   output logic               up_ready,
   input  logic               down_ready,
   output logic               valid_ff,
   output prod_set_type       prod_ff
);

   data_type     mat_ff [ELEMS];
   data_type     vec [4];
   prod_set_type prod_in;
   logic         valid_in;
   logic         xform;

   assign xform    = accept && (kind == KIND_POINT || kind == KIND_VECTOR);
   assign up_ready = !valid_ff || down_ready;

   assign vec[0] = in_x;
   assign vec[1] = in_y;
   assign vec[2] = in_z;
   assign vec[3] = in_w;

   // products against the store as it stands before this beat
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int i = 0; i < 4; i++) begin
            if (j == 3 && kind == KIND_POINT) begin
               prod_in.p[4*j+i] = prod_type'(mat_ff[4*j+i]) <<< FRAC_BITS;
            end else begin
               // sign-extended 32-bit operands, exact 64-bit product
               prod_in.p[4*j+i] = prod_type'(vec[j]) * prod_type'(mat_ff[4*j+i]);
            end
         end
      end
   end

   // matrix store, written by load beats
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ELEMS; k++) begin
            mat_ff[k] <= '0;
         end
      end else if (accept && kind == KIND_LOAD) begin
         mat_ff[elem_index] <= elem_value;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (up_ready) begin
         valid_in = xform;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && xform) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ----- hw/rtl/mvt_reduce.sv -----
// Two adder stages: pair sums, then the full sum with the rounding offset.
module mvt_reduce
   import mvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  prod_set_type in_prod,
   output logic         up_ready,
   input  logic         down_ready,
   output logic         valid_ff,
   output sum_set_type  sum_ff
);

   localparam sum_type HALF = sum_type'(1) <<< (FRAC_BITS - 1);

   sum_type     pair_ff [4][2];
   sum_type     pair_in [4][2];
   sum_set_type sum_in;
   logic        pair_valid_ff;
   logic        pair_valid_in;
   logic        valid_in;
   logic        pair_ready;
   logic        sum_ready;

   assign sum_ready  = !valid_ff || down_ready;
   assign pair_ready = !pair_valid_ff || sum_ready;
   assign up_ready   = pair_ready;

   // stage A: columns 0+1 and 2+3 of each component
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pair_in[i][0] = sum_type'(in_prod.p[i])     + sum_type'(in_prod.p[4+i]);
         pair_in[i][1] = sum_type'(in_prod.p[8+i])   + sum_type'(in_prod.p[12+i]);
      end
   end

   // stage B: full sum, half an LSB added for round half up
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sum_in.s[i] = pair_ff[i][0] + pair_ff[i][1] + HALF;
      end
   end

   always_comb begin
      pair_valid_in = pair_valid_ff;
      valid_in      = valid_ff;
      if (pair_ready) begin
         pair_valid_in = in_valid;
      end
      if (sum_ready) begin
         valid_in = pair_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         pair_valid_ff <= pair_valid_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair_ready && in_valid) begin
         pair_ff <= pair_in;
      end
      if (sum_ready && pair_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ----- hw/rtl/mvt_sat.sv -----
// Output stage: drop the fraction bits, clip to 32 bits, flag any clip.
module mvt_sat
   import mvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  sum_set_type  in_sum,
   output logic         up_ready,
   input  logic         down_ready,
   output logic         valid_ff,
   output rsp_data_type data_ff
);

   localparam int TOP_LO = DATA_W - 1 + FRAC_BITS;
   localparam int HI_W   = SUM_W - TOP_LO;

   data_type     comp [4];
   logic [3:0]   clip;
   rsp_data_type data_in;
   logic         valid_in;

   assign up_ready = !valid_ff || down_ready;

   // in range when every bit above the result's sign bit copies it
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         clip[i] = !(in_sum.s[i][SUM_W-1:TOP_LO] == {HI_W{1'b0}} ||
                     in_sum.s[i][SUM_W-1:TOP_LO] == {HI_W{1'b1}});
         if (clip[i]) begin
            comp[i] = in_sum.s[i][SUM_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            comp[i] = in_sum.s[i][TOP_LO:FRAC_BITS];
         end
      end
      data_in.out_x     = comp[0];
      data_in.out_y     = comp[1];
      data_in.out_z     = comp[2];
      data_in.out_w     = comp[3];
      data_in.saturated = |clip;
   end

   always_comb begin
      valid_in = valid_ff;
      if (up_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- hw/rtl/matrix_vector_transform.sv -----
// 4x4 matrix times 4-wide vector in signed fixed point (FRAC_BITS fraction bits,
// Q16.16 by default). The matrix is column-major: element k at index k, reset to
// zero. A load beat (kind 0) writes one element and gives no result; kind 3 is
// dropped. A point beat (kind 1, w taken as 1.0) or vector beat (kind 2) gives
// one result: out_i = x*m[i] + y*m[4+i] + z*m[8+i] + w*m[12+i], summed exactly,
// rounded half up and clipped to 32 bits, with saturated set if any component
// clipped. A transform sees every load accepted before it. Throughput is one beat
// per cycle while the response side takes results. Four register stages
// (multiply, two adder stages, clip) lie between an accepted beat and its result
// on the response port. Each stage holds its own valid bit, so bubbles collapse;
// behind a waiting result the request side keeps accepting until the three
// stages in front of the output register are full.
module matrix_vector_transform
   import mvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   mvt_req_if.sink   req_bus,
   mvt_rsp_if.source rsp_bus
);

   logic         accept;
   logic         mul_valid;
   prod_set_type mul_prod;
   logic         red_ready;
   logic         red_valid;
   sum_set_type  red_sum;
   logic         sat_ready;
   rsp_data_type rsp_data;

   assign accept = req_bus.valid && req_bus.ready;

   mvt_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_bus.kind),
      .elem_index (req_bus.elem_index),
      .elem_value (req_bus.elem_value),
      .in_x       (req_bus.in_x),
      .in_y       (req_bus.in_y),
      .in_z       (req_bus.in_z),
      .in_w       (req_bus.in_w),
      .up_ready   (req_bus.ready),
      .down_ready (red_ready),
      .valid_ff   (mul_valid),
      .prod_ff    (mul_prod)
   );

   mvt_reduce #(
      .FRAC_BITS (FRAC_BITS)
   ) u_reduce (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mul_valid),
      .in_prod    (mul_prod),
      .up_ready   (red_ready),
      .down_ready (sat_ready),
      .valid_ff   (red_valid),
      .sum_ff     (red_sum)
   );

   mvt_sat #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sat (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (red_valid),
      .in_sum     (red_sum),
      .up_ready   (sat_ready),
      .down_ready (rsp_bus.ready),
      .valid_ff   (rsp_bus.valid),
      .data_ff    (rsp_data)
   );

   assign rsp_bus.out_x     = rsp_data.out_x;
   assign rsp_bus.out_y     = rsp_data.out_y;
   assign rsp_bus.out_z     = rsp_data.out_z;
   assign rsp_bus.out_w     = rsp_data.out_w;
   assign rsp_bus.saturated = rsp_data.saturated;

   // a product set stalled by the adders is still there next cycle
   a_mul_hold: assert property (@(posedge clock) disable iff (reset)
      mul_valid && !red_ready |=> mul_valid)
      else $error("product stage dropped a stalled beat");

   // a transform into an empty pipe reaches the response port without a stall
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_bus.kind == KIND_POINT || req_bus.kind == KIND_VECTOR) &&
       !mul_valid && !red_valid && !rsp_bus.valid) |-> ##4 rsp_bus.valid)
      else $error("transform beat did not reach the output in four cycles");

   // a clip flag always comes with at least one component at a bound
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.saturated |->
         (rsp_bus.out_x == SAT_MAX || rsp_bus.out_x == SAT_MIN ||
          rsp_bus.out_y == SAT_MAX || rsp_bus.out_y == SAT_MIN ||
          rsp_bus.out_z == SAT_MAX || rsp_bus.out_z == SAT_MIN ||
          rsp_bus.out_w == SAT_MAX || rsp_bus.out_w == SAT_MIN))
      else $error("saturated set with no component at a bound");

   // nothing is in flight right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && !mul_valid && !red_valid)
      else $error("pipeline not empty after reset");

endmodule

// ----- tb/sv/matrix_vector_transform_tb.sv -----
module matrix_vector_transform_tb;
   import mvt_pkg::*;

   localparam int FRAC            = 16;
   localparam int CLK_PERIOD      = 12;
   localparam int TIMEOUT_CYCLES  = 200000;
   localparam int RANDOM_ITEMS    = 1850;
   localparam int IDLE_PCT        = 32;
   // accepted-beat window in which neither side idles
   localparam int BURST_FROM      = 700;
   localparam int BURST_TO        = 1100;
   // kind code the block drops
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [INDEX_W-1:0] elem_index;
      data_type           elem_value;
      data_type           x;
      data_type           y;
      data_type           z;
      data_type           w;
   } req_beat_type;

   logic clock;
   logic reset;

   mvt_req_if req_bus ();
   mvt_rsp_if rsp_bus ();

   matrix_vector_transform #(.FRAC_BITS(FRAC)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   req_beat_type pending_beats[$];
   rsp_data_type predicted_vertices[$];
   data_type     shadow_matrix[ELEMS];
   logic         req_taken;
   int           beats_taken;
   int           mismatch_count;

   // clock, plus known values on every block input from time zero
   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_taken           = 1'b0;
      beats_taken         = 0;
      mismatch_count      = 0;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_LOAD;
      req_bus.elem_index  = '0;
      req_bus.elem_value  = '0;
      req_bus.in_x        = '0;
      req_bus.in_y        = '0;
      req_bus.in_z        = '0;
      req_bus.in_w        = '0;
      rsp_bus.ready       = 1'b0;
      for (int k = 0; k < ELEMS; k++) shadow_matrix[k] = '0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic no_idle_now();
      return (beats_taken >= BURST_FROM) && (beats_taken < BURST_TO);
   endfunction

   // Q16.16 value: mostly modest magnitudes so results stay in range,
   // with full-range words and the extremes mixed in
   function automatic data_type pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: begin
            case ($urandom_range(0, 4))
               0:       return SAT_MIN;
               1:       return SAT_MAX;
               2:       return '0;
               3:       return -32'sd1;
               default: return 32'sh0001_0000;
            endcase
         end
         1, 2:    return data_type'($urandom);
         default: return data_type'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   task automatic queue_load(input logic [INDEX_W-1:0] idx, input data_type value);
      req_beat_type b;
      b.kind       = KIND_LOAD;
      b.elem_index = idx;
      b.elem_value = value;
      b.x          = data_type'($urandom);
      b.y          = data_type'($urandom);
      b.z          = data_type'($urandom);
      b.w          = data_type'($urandom);
      pending_beats.push_back(b);
   endtask

   task automatic queue_xform(input logic [1:0] kind, input data_type x, input data_type y,
                              input data_type z, input data_type w);
      req_beat_type b;
      b.kind       = kind;
      b.elem_index = INDEX_W'($urandom_range(0, ELEMS - 1));
      b.elem_value = data_type'($urandom);
      b.x          = x;
      b.y          = y;
      b.z          = z;
      b.w          = w;
      pending_beats.push_back(b);
   endtask

   // exact 4-term dot product per component, round half up, clip to 32 bits
   function automatic rsp_data_type transform_vertex(req_beat_type b);
      rsp_data_type        r;
      data_type            vin[4];
      data_type            comp[4];
      logic signed [67:0]  acc;
      logic signed [67:0]  q;
      logic                clipped;
      vin[0]  = b.x;
      vin[1]  = b.y;
      vin[2]  = b.z;
      vin[3]  = (b.kind == KIND_POINT) ? data_type'(1 << FRAC) : b.w;
      clipped = 1'b0;
      for (int i = 0; i < 4; i++) begin
         acc = '0;
         for (int j = 0; j < 4; j++) begin
            acc = acc + 68'(longint'(vin[j]) * longint'(shadow_matrix[4 * j + i]));
         end
         acc = acc + (68'sd1 <<< (FRAC - 1));
         q   = acc >>> FRAC;
         if (q > 68'sd2147483647) begin
            comp[i] = SAT_MAX;
            clipped = 1'b1;
         end else if (q < -68'sd2147483648) begin
            comp[i] = SAT_MIN;
            clipped = 1'b1;
         end else begin
            comp[i] = q[31:0];
         end
      end
      r.out_x     = comp[0];
      r.out_y     = comp[1];
      r.out_z     = comp[2];
      r.out_w     = comp[3];
      r.saturated = clipped;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // request driver: a beat stays on the bus until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_taken) begin
         // hold current beat
      end else if (pending_beats.size() != 0 &&
                   (no_idle_now() || $urandom_range(0, 99) >= IDLE_PCT)) begin
         req_bus.valid      <= 1'b1;
         req_bus.kind       <= pending_beats[0].kind;
         req_bus.elem_index <= pending_beats[0].elem_index;
         req_bus.elem_value <= pending_beats[0].elem_value;
         req_bus.in_x       <= pending_beats[0].x;
         req_bus.in_y       <= pending_beats[0].y;
         req_bus.in_z       <= pending_beats[0].z;
         req_bus.in_w       <= pending_beats[0].w;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // result side backpressure
   always @(negedge clock) begin
      rsp_bus.ready <= no_idle_now() || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // monitor: check result beats, predict from accepted request beats
   always @(posedge clock) begin
      rsp_data_type want;
      req_beat_type beat;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_vertices.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h %h %h %h sat %b",
                        $time, rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_z,
                        rsp_bus.out_w, rsp_bus.saturated);
               mismatch_count++;
            end else begin
               want = predicted_vertices.pop_front();
               check_field("out_x", want.out_x, rsp_bus.out_x);
               check_field("out_y", want.out_y, rsp_bus.out_y);
               check_field("out_z", want.out_z, rsp_bus.out_z);
               check_field("out_w", want.out_w, rsp_bus.out_w);
               check_field("saturated", 32'(want.saturated), 32'(rsp_bus.saturated));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            beat.kind       = req_bus.kind;
            beat.elem_index = req_bus.elem_index;
            beat.elem_value = req_bus.elem_value;
            beat.x          = req_bus.in_x;
            beat.y          = req_bus.in_y;
            beat.z          = req_bus.in_z;
            beat.w          = req_bus.in_w;
            req_taken       = 1'b1;
            beats_taken++;
            void'(pending_beats.pop_front());
            case (beat.kind)
               KIND_LOAD:               shadow_matrix[beat.elem_index] = beat.elem_value;
               KIND_POINT, KIND_VECTOR: predicted_vertices.push_back(transform_vertex(beat));
               default:                 ; // unused kind is dropped
            endcase
         end
      end
   end

   // stimulus and end of run
   initial begin
      int issued;
      int sel;
      data_type corner_vals[ELEMS];

      corner_vals = '{32'sh0000_8000, 32'shFFFF_8000, SAT_MAX, SAT_MIN,
                      32'sh0001_0000, 32'sh0, SAT_MIN, SAT_MAX,
                      -32'sd1, 32'sd1, SAT_MAX, SAT_MIN,
                      32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_7FFF, 32'sh0000_8000};

      // matrix is zero after reset
      queue_xform(KIND_POINT, SAT_MAX, SAT_MIN, 32'sd1, SAT_MAX);
      // unused kind must leave the matrix alone
      queue_xform(KIND_UNUSED, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
      for (int k = 0; k < ELEMS; k++) queue_load(INDEX_W'(k), corner_vals[k]);
      // rounding ties: +0.5 lsb rounds up, -0.5 lsb rounds to zero
      queue_xform(KIND_VECTOR, 32'sd1, 32'sd0, 32'sd0, 32'sd0);
      queue_xform(KIND_VECTOR, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
      queue_xform(KIND_VECTOR, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
      // point mode ignores w
      queue_xform(KIND_POINT, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN);
      queue_xform(KIND_POINT, 32'sd0, 32'sd0, 32'sd0, SAT_MAX);
      queue_xform(KIND_VECTOR, 32'sd0, 32'sd0, 32'sd0, SAT_MAX);
      queue_xform(KIND_UNUSED, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
      queue_xform(KIND_VECTOR, 32'sh0001_0000, -32'sd1, 32'sh0000_8000, 32'sd0);

      // random part, mostly matrix loads and transforms with random content
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            // whole new matrix, then the four columns of a second matrix
            for (int k = 0; k < ELEMS; k++) queue_load(INDEX_W'(k), pick_value());
            for (int c = 0; c < 4; c++)
               queue_xform(KIND_VECTOR, pick_value(), pick_value(), pick_value(), pick_value());
            issued += ELEMS + 4;
         end else if (sel == 1) begin
            queue_xform(KIND_UNUSED, data_type'($urandom), data_type'($urandom),
                        data_type'($urandom), data_type'($urandom));
         end else if (sel < 8) begin
            queue_load(INDEX_W'($urandom_range(0, ELEMS - 1)), pick_value());
            issued++;
         end else if (sel < 12) begin
            queue_xform(KIND_POINT, pick_value(), pick_value(), pick_value(),
                        data_type'($urandom));
            issued++;
         end else begin
            queue_xform(KIND_VECTOR, pick_value(), pick_value(), pick_value(), pick_value());
            issued++;
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      while (predicted_vertices.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- matrix_vector_transform.f -----
hw/rtl/mvt_pkg.sv
hw/rtl/mvt_req_if.sv
hw/rtl/mvt_rsp_if.sv
hw/rtl/mvt_mul.sv
hw/rtl/mvt_reduce.sv
hw/rtl/mvt_sat.sv
hw/rtl/matrix_vector_transform.sv
tb/sv/matrix_vector_transform_tb.sv
